/* hw/rtl/kes_pkg.sv */
package kes_pkg;

    // Fixed field widths
    localparam int ZONE_BITS = 6;
    localparam int COST_BITS = 16;
    localparam int ZCNT_BITS = 7;

    localparam int MAX_ZONES_DEFAULT = 64;

    // APB register map
    localparam int APB_AW = 2;
    localparam logic [APB_AW-1:0] ADDR_ZONE_COUNT = 2'd0;
    localparam logic [ZCNT_BITS-1:0] ZONE_COUNT_RESET = 7'd64;

    // Item modes
    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_EDGE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_SELECTED = 2'd0;
    localparam logic [1:0] STATUS_CYCLE    = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;
    localparam logic [1:0] STATUS_CLEARED  = 2'd3;

    typedef struct packed {
        logic                 mode;
        logic [ZONE_BITS-1:0] edge_from;
        logic [ZONE_BITS-1:0] edge_to;
        logic [COST_BITS-1:0] edge_cost;
        logic                 final_edge;
    } item_t;

    typedef struct packed {
        logic                 accepted;
        logic [1:0]           status;
        logic [ZONE_BITS-1:0] tree_from;
        logic [ZONE_BITS-1:0] tree_to;
        logic [COST_BITS-1:0] tree_cost;
        logic                 run_end;
    } result_t;

endpackage

/* hw/rtl/kes_link_ram.sv */
// Parent-link store: one write port, one read port, registered read data.
module kes_link_ram #(
    parameter int MAX_ZONES = kes_pkg::MAX_ZONES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(MAX_ZONES)-1:0] waddr,
    input  logic [$clog2(MAX_ZONES)-1:0] wdata,
    input  logic                         re,
    input  logic [$clog2(MAX_ZONES)-1:0] raddr,
    output logic [$clog2(MAX_ZONES)-1:0] rdata
);
    localparam int ZW = $clog2(MAX_ZONES);

    logic [ZW-1:0] link_mem [MAX_ZONES];
    logic [ZW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= link_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/kruskal_edge_selector.sv */
// Edge item: walk to the root and compress from edge_from, then from edge_to, then link
//   and report; an out-of-range edge just reports; a clear sweeps every link, then reports.
// Throughput: one item at a time; busy stays high until the result step has issued,
//   and the next item may be taken in the cycle that done is shown.
// Reset: async, active low; then an init sweep writes every link to its own index
//   with busy high. done is a one-cycle strobe; the receiver cannot stall.
module kruskal_edge_selector #(
    parameter int MAX_ZONES = kes_pkg::MAX_ZONES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kes_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // command side
    input  logic                        start,
    output logic                        busy,
    input  kes_pkg::item_t              item,
    // result side
    output logic                        done,
    output kes_pkg::result_t            result
);
    import kes_pkg::*;

    localparam int ZW    = $clog2(MAX_ZONES);
    localparam int UPC_W = 5;

    // ------------------------------------------------------------------
    // Microprogram step addresses
    // ------------------------------------------------------------------
    localparam logic [UPC_W-1:0] S_IDLE    = 5'd0;
    localparam logic [UPC_W-1:0] S_LDU     = 5'd1;   // cur <= from
    localparam logic [UPC_W-1:0] S_FU0     = 5'd2;   // read link[cur]
    localparam logic [UPC_W-1:0] S_FU1     = 5'd3;   // step up, loop until self link
    localparam logic [UPC_W-1:0] S_CU0     = 5'd4;   // back to start for compression
    localparam logic [UPC_W-1:0] S_CU1     = 5'd5;   // at root? else read link[cur]
    localparam logic [UPC_W-1:0] S_CU2     = 5'd6;   // link[cur] <= root, cur <= old link
    localparam logic [UPC_W-1:0] S_LDV     = 5'd7;   // ru <= root, cur <= to
    localparam logic [UPC_W-1:0] S_FV0     = 5'd8;
    localparam logic [UPC_W-1:0] S_FV1     = 5'd9;
    localparam logic [UPC_W-1:0] S_CV0     = 5'd10;
    localparam logic [UPC_W-1:0] S_CV1     = 5'd11;
    localparam logic [UPC_W-1:0] S_CV2     = 5'd12;
    localparam logic [UPC_W-1:0] S_LINK    = 5'd13;  // union + report
    localparam logic [UPC_W-1:0] S_RANGE   = 5'd14;
    localparam logic [UPC_W-1:0] S_CLR     = 5'd15;  // sweep, one entry per cycle
    localparam logic [UPC_W-1:0] S_CLRDONE = 5'd16;
    localparam logic [UPC_W-1:0] S_INIT    = 5'd17;  // post-reset sweep, no report

    // Jump conditions: taken -> tgt_t, else tgt_f
    localparam logic [2:0] C_ALWAYS     = 3'd0;
    localparam logic [2:0] C_DISPATCH   = 3'd1;
    localparam logic [2:0] C_NOT_ROOT   = 3'd2;  // link[cur] != cur
    localparam logic [2:0] C_AT_ROOT    = 3'd3;  // cur == root
    localparam logic [2:0] C_SWEEP_MORE = 3'd4;

    // cur register source
    localparam logic [2:0] CUR_HOLD  = 3'd0;
    localparam logic [2:0] CUR_FROM  = 3'd1;
    localparam logic [2:0] CUR_TO    = 3'd2;
    localparam logic [2:0] CUR_RDATA = 3'd3;
    localparam logic [2:0] CUR_START = 3'd4;

    // link store write kind
    localparam logic [1:0] WR_NONE     = 2'd0;
    localparam logic [1:0] WR_COMPRESS = 2'd1;
    localparam logic [1:0] WR_LINK     = 2'd2;
    localparam logic [1:0] WR_SWEEP    = 2'd3;

    // result kind
    localparam logic [1:0] EM_NONE  = 2'd0;
    localparam logic [1:0] EM_LINK  = 2'd1;
    localparam logic [1:0] EM_RANGE = 2'd2;
    localparam logic [1:0] EM_CLEAR = 2'd3;

    typedef struct packed {
        logic [2:0]       cond;
        logic [UPC_W-1:0] tgt_t;
        logic [UPC_W-1:0] tgt_f;
        logic [2:0]       cur_sel;
        logic             root_ld;
        logic             ru_ld;
        logic             rd_en;
        logic [1:0]       wr_sel;
        logic             sweep_inc;
        logic [1:0]       emit;
    } ucode_t;

    function automatic ucode_t uw(
        input logic [2:0]       cond,
        input logic [UPC_W-1:0] tgt_t,
        input logic [UPC_W-1:0] tgt_f,
        input logic [2:0]       cur_sel,
        input logic             root_ld,
        input logic             ru_ld,
        input logic             rd_en,
        input logic [1:0]       wr_sel,
        input logic             sweep_inc,
        input logic [1:0]       emit
    );
        ucode_t w;
        w.cond      = cond;
        w.tgt_t     = tgt_t;
        w.tgt_f     = tgt_f;
        w.cur_sel   = cur_sel;
        w.root_ld   = root_ld;
        w.ru_ld     = ru_ld;
        w.rd_en     = rd_en;
        w.wr_sel    = wr_sel;
        w.sweep_inc = sweep_inc;
        w.emit      = emit;
        return w;
    endfunction

    // Control store. Root walk and compression are written once per endpoint.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] a);
        ucode_t w;
        unique case (a)
            S_IDLE:    w = uw(C_DISPATCH, S_IDLE, S_IDLE, CUR_HOLD, 1'b0, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
            S_LDU:     w = uw(C_ALWAYS, S_FU0, S_FU0, CUR_FROM, 1'b0, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
            S_FU0:     w = uw(C_ALWAYS, S_FU1, S_FU1, CUR_HOLD, 1'b0, 1'b0, 1'b1,
                              WR_NONE, 1'b0, EM_NONE);
            S_FU1:     w = uw(C_NOT_ROOT, S_FU0, S_CU0, CUR_RDATA, 1'b1, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
            S_CU0:     w = uw(C_ALWAYS, S_CU1, S_CU1, CUR_START, 1'b0, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
            S_CU1:     w = uw(C_AT_ROOT, S_LDV, S_CU2, CUR_HOLD, 1'b0, 1'b0, 1'b1,
                              WR_NONE, 1'b0, EM_NONE);
            S_CU2:     w = uw(C_ALWAYS, S_CU1, S_CU1, CUR_RDATA, 1'b0, 1'b0, 1'b0,
                              WR_COMPRESS, 1'b0, EM_NONE);
            S_LDV:     w = uw(C_ALWAYS, S_FV0, S_FV0, CUR_TO, 1'b0, 1'b1, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
            S_FV0:     w = uw(C_ALWAYS, S_FV1, S_FV1, CUR_HOLD, 1'b0, 1'b0, 1'b1,
                              WR_NONE, 1'b0, EM_NONE);
            S_FV1:     w = uw(C_NOT_ROOT, S_FV0, S_CV0, CUR_RDATA, 1'b1, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
            S_CV0:     w = uw(C_ALWAYS, S_CV1, S_CV1, CUR_START, 1'b0, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
            S_CV1:     w = uw(C_AT_ROOT, S_LINK, S_CV2, CUR_HOLD, 1'b0, 1'b0, 1'b1,
                              WR_NONE, 1'b0, EM_NONE);
            S_CV2:     w = uw(C_ALWAYS, S_CV1, S_CV1, CUR_RDATA, 1'b0, 1'b0, 1'b0,
                              WR_COMPRESS, 1'b0, EM_NONE);
            S_LINK:    w = uw(C_ALWAYS, S_IDLE, S_IDLE, CUR_HOLD, 1'b0, 1'b0, 1'b0,
                              WR_LINK, 1'b0, EM_LINK);
            S_RANGE:   w = uw(C_ALWAYS, S_IDLE, S_IDLE, CUR_HOLD, 1'b0, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_RANGE);
            S_CLR:     w = uw(C_SWEEP_MORE, S_CLR, S_CLRDONE, CUR_HOLD, 1'b0, 1'b0, 1'b0,
                              WR_SWEEP, 1'b1, EM_NONE);
            S_CLRDONE: w = uw(C_ALWAYS, S_IDLE, S_IDLE, CUR_HOLD, 1'b0, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_CLEAR);
            S_INIT:    w = uw(C_SWEEP_MORE, S_INIT, S_IDLE, CUR_HOLD, 1'b0, 1'b0, 1'b0,
                              WR_SWEEP, 1'b1, EM_NONE);
            default:   w = uw(C_ALWAYS, S_IDLE, S_IDLE, CUR_HOLD, 1'b0, 1'b0, 1'b0,
                              WR_NONE, 1'b0, EM_NONE);
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    logic [ZCNT_BITS-1:0] zone_count_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ZONE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_count_reg <= ZONE_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            zone_count_reg <= pwdata[ZCNT_BITS-1:0];
        end
    end

    assign prdata = (paddr == ADDR_ZONE_COUNT) ? 32'(zone_count_reg) : 32'd0;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    ucode_t           ctrl;
    logic             accept;
    logic             from_ok;
    logic             to_ok;
    logic             cond_hit;

    // datapath
    item_t            item_reg;
    logic [ZW-1:0]    cur_reg;
    logic [ZW-1:0]    start_reg;     // walk origin, revisited for compression
    logic [ZW-1:0]    root_reg;
    logic [ZW-1:0]    ru_reg;        // root of edge_from
    logic [ZW-1:0]    sweep_cnt_reg;
    logic             sweep_last;

    // link store
    logic             ram_we;
    logic [ZW-1:0]    ram_waddr;
    logic [ZW-1:0]    ram_wdata;
    logic [ZW-1:0]    ram_rdata;

    logic             done_reg;
    result_t          result_reg;

    assign ctrl   = ucode_rom(upc_reg);
    assign busy   = (upc_reg != S_IDLE);
    assign accept = start && !busy;

    // Effective limit is min(zone_count, MAX_ZONES); zero rejects everything.
    assign from_ok = (32'(item.edge_from) < 32'(zone_count_reg))
                  && (32'(item.edge_from) < MAX_ZONES);
    assign to_ok   = (32'(item.edge_to) < 32'(zone_count_reg))
                  && (32'(item.edge_to) < MAX_ZONES);

    assign sweep_last = (sweep_cnt_reg == ZW'(MAX_ZONES - 1));

    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:     cond_hit = 1'b1;
            C_NOT_ROOT:   cond_hit = (ram_rdata != cur_reg);
            C_AT_ROOT:    cond_hit = (cur_reg == root_reg);
            C_SWEEP_MORE: cond_hit = !sweep_last;
            default:      cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = cond_hit ? ctrl.tgt_t : ctrl.tgt_f;
        if (ctrl.cond == C_DISPATCH)
        begin
            priority if (!accept)
            begin
                upc_next = S_IDLE;
            end
            else if (item.mode == MODE_CLEAR)
            begin
                upc_next = S_CLR;
            end
            else if (!from_ok || !to_ok)
            begin
                upc_next = S_RANGE;
            end
            else
            begin
                upc_next = S_LDU;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= S_INIT;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (ctrl.sweep_inc)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end

        unique case (ctrl.cur_sel)
            CUR_FROM:
            begin
                cur_reg   <= ZW'(item_reg.edge_from);
                start_reg <= ZW'(item_reg.edge_from);
            end
            CUR_TO:
            begin
                cur_reg   <= ZW'(item_reg.edge_to);
                start_reg <= ZW'(item_reg.edge_to);
            end
            CUR_RDATA: cur_reg <= ram_rdata;
            CUR_START: cur_reg <= start_reg;
            default:   cur_reg <= cur_reg;
        endcase

        // walk ends when link[cur] == cur, so latching cur every step leaves the root
        if (ctrl.root_ld)
        begin
            root_reg <= cur_reg;
        end
        if (ctrl.ru_ld)
        begin
            ru_reg <= root_reg;
        end
    end

    // ------------------------------------------------------------------
    // Link store port mux
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (ctrl.wr_sel)
            WR_COMPRESS:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = root_reg;
            end
            WR_LINK:
            begin
                ram_we    = (ru_reg != root_reg);
                ram_waddr = ru_reg;
                ram_wdata = root_reg;
            end
            WR_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = sweep_cnt_reg;
            end
            default:
            begin
                ram_we    = 1'b0;
                ram_waddr = cur_reg;
                ram_wdata = root_reg;
            end
        endcase
    end

    kes_link_ram #(
        .MAX_ZONES (MAX_ZONES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctrl.rd_en),
        .raddr (cur_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (ctrl.emit != EM_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.emit)
            EM_LINK:
            begin
                result_reg.accepted  <= (ru_reg != root_reg);
                result_reg.status    <= (ru_reg != root_reg) ? STATUS_SELECTED : STATUS_CYCLE;
                result_reg.tree_from <= item_reg.edge_from;
                result_reg.tree_to   <= item_reg.edge_to;
                result_reg.tree_cost <= item_reg.edge_cost;
                result_reg.run_end   <= item_reg.final_edge;
            end
            EM_RANGE:
            begin
                result_reg.accepted  <= 1'b0;
                result_reg.status    <= STATUS_RANGE;
                result_reg.tree_from <= item_reg.edge_from;
                result_reg.tree_to   <= item_reg.edge_to;
                result_reg.tree_cost <= item_reg.edge_cost;
                result_reg.run_end   <= item_reg.final_edge;
            end
            EM_CLEAR:
            begin
                result_reg.accepted  <= 1'b0;
                result_reg.status    <= STATUS_CLEARED;
                result_reg.tree_from <= '0;
                result_reg.tree_to   <= '0;
                result_reg.tree_cost <= '0;
                result_reg.run_end   <= 1'b0;
            end
            default:
            begin
                result_reg <= result_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not start the program");

    a_done_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer still running");

    a_done_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctrl.emit != EM_NONE))
        else $error("result beat without an emitting step");

    a_sweep_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (sweep_cnt_reg == '0))
        else $error("sweep counter not rewound");

    a_compress_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr_sel == WR_COMPRESS) |-> (cur_reg != root_reg))
        else $error("compression rewrote the root itself");

endmodule

/* bench/kruskal_edge_selector_tb.sv */
module kruskal_edge_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kes_pkg::*;

    localparam int MAX_ZONES = MAX_ZONES_DEFAULT;
    // Covers the longest edge walk, with margin for the tail.
    localparam int SETTLE_CYCLES = 12 + 8 * MAX_ZONES;
    // Worst case per item is roughly a full-depth walk plus a long gap; ~810 items,
    // several times over.
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   start = 1'b0;
    logic                   busy;
    item_t                  item = '0;
    logic                   done;
    result_t                result;

    // Shadow forest, updated per accepted beat; zone_count register, updated per APB write.
    logic [ZONE_BITS-1:0]   zone_link [MAX_ZONES];
    logic [ZCNT_BITS-1:0]   zone_cfg;

    result_t                verdict_q [$];
    int                     mismatch_count = 0;
    int                     cycle_count = 0;
    // When set, the command side offers items back to back with no idle gaps.
    bit                     steady_feed = 1'b0;

    kruskal_edge_selector #(
        .MAX_ZONES(MAX_ZONES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result)
    );

    always #5 clk = ~clk;

    // Hang guard: a stuck busy or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[kruskal_edge_selector] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Shadow forest
    // ---------------------------------------------------------------------

    // Effective zone limit: zone_count clamped to the table depth.
    function automatic int zone_limit();
        return (int'(zone_cfg) > MAX_ZONES) ? MAX_ZONES : int'(zone_cfg);
    endfunction

    function automatic void reset_forest();
        for (int i = 0; i < MAX_ZONES; i++)
            zone_link[i] = ZONE_BITS'(i);
    endfunction

    // Root walk, then a second pass that points every zone on the path at the root.
    function automatic logic [ZONE_BITS-1:0] find_root(input logic [ZONE_BITS-1:0] zone);
        logic [ZONE_BITS-1:0] root;
        logic [ZONE_BITS-1:0] cur;
        logic [ZONE_BITS-1:0] nxt;
        int                   steps;
        root = zone;
        steps = 0;
        while (steps < MAX_ZONES && zone_link[root] != root)
        begin
            root = zone_link[root];
            steps++;
        end
        cur = zone;
        steps = 0;
        while (steps < MAX_ZONES && cur != root)
        begin
            nxt = zone_link[cur];
            zone_link[cur] = root;
            cur = nxt;
            steps++;
        end
        return root;
    endfunction

    // Applies one accepted beat to the shadow forest and returns the verdict it must produce.
    function automatic result_t judge_edge(input item_t it);
        result_t              verdict;
        logic [ZONE_BITS-1:0] root_a;
        logic [ZONE_BITS-1:0] root_b;
        int                   lim;
        verdict = '0;
        // Clear resets the whole table regardless of zone_count; echo fields stay zero.
        if (it.mode == MODE_CLEAR)
        begin
            reset_forest();
            verdict.status = STATUS_CLEARED;
            return verdict;
        end
        verdict.tree_from = it.edge_from;
        verdict.tree_to   = it.edge_to;
        verdict.tree_cost = it.edge_cost;
        verdict.run_end   = it.final_edge;
        lim = zone_limit();
        // Either endpoint out of range: forest untouched.
        if (int'(it.edge_from) >= lim || int'(it.edge_to) >= lim)
        begin
            verdict.status = STATUS_RANGE;
            return verdict;
        end
        root_a = find_root(it.edge_from);
        root_b = find_root(it.edge_to);
        // Union links root of the first zone under root of the second. Self loops land
        // in the cycle branch since both roots match.
        if (root_a != root_b)
        begin
            zone_link[root_a] = root_b;
            verdict.accepted = 1'b1;
            verdict.status = STATUS_SELECTED;
        end
        else
            verdict.status = STATUS_CYCLE;
        return verdict;
    endfunction

    initial
    begin
        reset_forest();
        zone_cfg = ZONE_COUNT_RESET;
    end

    // ---------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, so every beat is taken here.
    // ---------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat with nothing outstanding (status %0d)", result.status);
                mismatch_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("accepted", 16'(want.accepted), 16'(result.accepted));
                check_field("status", 16'(want.status), 16'(result.status));
                check_field("tree_from", 16'(want.tree_from), 16'(result.tree_from));
                check_field("tree_to", 16'(want.tree_to), 16'(result.tree_to));
                check_field("tree_cost", want.tree_cost, result.tree_cost);
                check_field("run_end", 16'(want.run_end), 16'(result.run_end));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    function automatic item_t mk_item(input logic mode, input logic [ZONE_BITS-1:0] from,
                                      input logic [ZONE_BITS-1:0] to,
                                      input logic [COST_BITS-1:0] cost, input logic fin);
        item_t it;
        it.mode = mode;
        it.edge_from = from;
        it.edge_to = to;
        it.edge_cost = cost;
        it.final_edge = fin;
        return it;
    endfunction

    // Offers one beat after a random idle gap and returns at the edge that takes it.
    // start is only lowered when a gap follows, so it never toggles within one step.
    task automatic send_item(input item_t it);
        int gap;
        int pick;
        gap = 0;
        if (!steady_feed)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 3);
            else if (pick < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        verdict_q.push_back(judge_edge(it));
    endtask

    // Stops offering and waits until every outstanding verdict has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    // APB write: setup phase, then access phase; lands on the edge with pready high.
    task automatic write_zone_count(input logic [ZCNT_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ZONE_COUNT;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        zone_cfg = value;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Runs at the reset zone_count: field extremes, cycle and self-loop detection,
    // a deep chain that forces a long walk with compression, and clear.
    task automatic test_directed_edges();
        send_item(mk_item(MODE_CLEAR, 6'd63, 6'd63, 16'hFFFF, 1'b1));
        send_item(mk_item(MODE_EDGE, 6'd0, 6'd63, 16'h0000, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd63, 6'd0, 16'h0001, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd5, 6'd5, 16'h0002, 1'b0));
        // chain 10 -> 11 -> 12 -> 13 -> 14
        send_item(mk_item(MODE_EDGE, 6'd10, 6'd11, 16'h0010, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd11, 6'd12, 16'h0011, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd12, 6'd13, 16'h0012, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd13, 6'd14, 16'h0013, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd10, 6'd14, 16'h0014, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd10, 6'd0, 16'h5555, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd14, 6'd63, 16'hAAAA, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd62, 6'd61, 16'hFFFF, 1'b1));
        send_item(mk_item(MODE_CLEAR, 6'd0, 6'd0, 16'h0000, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd0, 6'd63, 16'h0100, 1'b0));
    endtask

    // Walks zone_count through its extremes: zero rejects everything, one allows only
    // the self loop, values past the table depth act as the full depth. The clear under
    // zone_count 1 must still wipe the 0-63 link made above.
    task automatic test_zone_limits();
        drain_results();
        write_zone_count(7'd0);
        send_item(mk_item(MODE_EDGE, 6'd0, 6'd0, 16'h0001, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd63, 6'd63, 16'hFFFF, 1'b1));
        drain_results();
        write_zone_count(7'd1);
        send_item(mk_item(MODE_EDGE, 6'd0, 6'd0, 16'h0002, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd0, 6'd1, 16'h0003, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd1, 6'd0, 16'h0004, 1'b1));
        send_item(mk_item(MODE_CLEAR, 6'd21, 6'd42, 16'h1234, 1'b0));
        drain_results();
        write_zone_count(7'd127);
        send_item(mk_item(MODE_EDGE, 6'd63, 6'd62, 16'h0005, 1'b0));
        drain_results();
        write_zone_count(7'd65);
        send_item(mk_item(MODE_EDGE, 6'd63, 6'd0, 16'h0006, 1'b0));
        drain_results();
        write_zone_count(7'd2);
        send_item(mk_item(MODE_EDGE, 6'd0, 6'd1, 16'h0007, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd1, 6'd0, 16'h0008, 1'b0));
        send_item(mk_item(MODE_EDGE, 6'd2, 6'd0, 16'h0009, 1'b1));
    endtask

    // Phases at several zone counts. Each run is mostly a proper Kruskal list: a clear,
    // then edges with rising cost over in-range zones, the last one flagged final.
    // Sprinkled in: skipped clears, out-of-range endpoints, stray costs and final flags.
    task automatic test_random_runs();
        logic [ZCNT_BITS-1:0] zc;
        int                   budget;
        int                   sent;
        int                   lim;
        int                   run_len;
        int                   cost;
        item_t                it;
        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: zc = 7'd64;
                1: zc = 7'd127;
                2: zc = 7'd0;
                3: zc = 7'd1;
                4: zc = 7'd2;
                5: zc = 7'd5;
                6: zc = 7'($urandom_range(3, 63));
                7: zc = 7'($urandom_range(65, 126));
                default: zc = 7'd64;
            endcase
            budget = (zc < 2) ? 25 : 105;
            drain_results();
            write_zone_count(zc);
            lim = zone_limit();
            sent = 0;
            while (sent < budget)
            begin
                steady_feed = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) != 0)
                begin
                    send_item(mk_item(MODE_CLEAR, 6'($urandom), 6'($urandom),
                                      16'($urandom), 1'($urandom)));
                    sent++;
                end
                run_len = $urandom_range(1, 2 * lim + 4);
                cost = $urandom_range(0, 4000);
                for (int k = 0; k < run_len && sent < budget; k++)
                begin
                    cost += $urandom_range(0, 700);
                    if (cost > 65535)
                        cost = 65535;
                    it = mk_item(MODE_EDGE, 6'($urandom), 6'($urandom), 16'(cost),
                                 1'(k == run_len - 1));
                    if (lim > 0 && $urandom_range(0, 9) != 0)
                    begin
                        it.edge_from = 6'($urandom_range(0, lim - 1));
                        it.edge_to = 6'($urandom_range(0, lim - 1));
                    end
                    if ($urandom_range(0, 15) == 0)
                        it.edge_cost = 16'($urandom);
                    if ($urandom_range(0, 15) == 0)
                        it.final_edge = 1'($urandom);
                    send_item(it);
                    sent++;
                end
            end
        end
        steady_feed = 1'b0;
    endtask

    initial
    begin
        // Reset once; the block then sweeps its link table with busy high, which
        // the first send simply waits out.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_zone_limits();
        test_random_runs();
        drain_results();
        // Quiet tail: any stray result beat would be flagged by the checker.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[kruskal_edge_selector] OK");
        else
            $display("[kruskal_edge_selector] ERROR");
        $finish;
    end

endmodule
